### src/pidsc_pkg.sv
// Package of the PID speed controller: field widths, term limit,
// register indexes and result status codes.
// Used by the channel interfaces and by the top level.
`default_nettype none

package pidsc_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned BOUND_W   = 31;
  localparam int unsigned DT_W      = 16;
  localparam int unsigned DIR_W     = 2;
  localparam int unsigned TERM_W    = 48;
  localparam int unsigned REG_IDX_W = 3;

  // Largest magnitude of a P, I or D term and of the final sum.
  localparam logic signed [TERM_W-1:0] TERM_MAX = 48'sh7FFF_FFFF_FFFF;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_GAIN_P      = 3'd0,
    REG_GAIN_I      = 3'd1,
    REG_GAIN_D      = 3'd2,
    REG_INT_BOUND   = 3'd3,
    REG_DRIVE_BOUND = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

endpackage

`default_nettype wire

### src/pidsc_if.sv
// Valid/ready channel interfaces of the PID speed controller: one for the
// input word and one for the result word. Depends on pidsc_pkg.
`default_nettype none

interface pidsc_in_if;
  import pidsc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     action;
  logic signed [WORD_W-1:0] target_speed;
  logic signed [WORD_W-1:0] measured_speed;
  logic [DT_W-1:0]          time_step;
  logic signed [DIR_W-1:0]  limit_direction;
  logic signed [WORD_W-1:0] window_low;
  logic signed [WORD_W-1:0] window_high;

  modport source (
    output valid, action, target_speed, measured_speed, time_step,
           limit_direction, window_low, window_high,
    input  ready
  );

  modport sink (
    input  valid, action, target_speed, measured_speed, time_step,
           limit_direction, window_low, window_high,
    output ready
  );
endinterface

interface pidsc_out_if;
  import pidsc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] drive;
  status_t                  status;
  logic                     integral_frozen;

  modport source (
    output valid, drive, status, integral_frozen,
    input  ready
  );

  modport sink (
    input  valid, drive, status, integral_frozen,
    output ready
  );
endinterface

`default_nettype wire

### src/pid_speed_controller_antiwindup.sv
// PID speed controller with conditional-integration anti-windup, Q16.16.
// Depends on pidsc_pkg and on the channel interfaces in pidsc_if.sv.
//
// Usage: one input word arrives on req (valid/ready) and gives exactly one
// result word on rsp (valid/ready). The gains and bounds are written through
// wr_en, wr_index and wr_data while the block is idle; every write to a
// listed register also clears the integral and the previous error.
// A clear word, a word with a zero time step or an inverted window, and a
// word whose narrowed window is empty finish in the accept cycle, so the
// result appears in the next cycle. A control step runs on one shared 32x16
// multiplier, digit by digit, and on a radix-4 divider for the derivative;
// it forms the P term, the error times the time step, the D term, the I term
// and the sum, and the I term again when integration is held. The divider
// runs 32 iterations. One word is worked on at a time; the next word is
// accepted once the block is back in idle while the result register is free
// or being read. A stalled receiver holds the result register and keeps the
// block from finishing the next control step. Synchronous reset clears the
// registers and the controller state to zero and empties the result register.
`default_nettype none

module pid_speed_controller_antiwindup (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [pidsc_pkg::REG_IDX_W-1:0]     wr_index,
  input  logic [pidsc_pkg::WORD_W-1:0]        wr_data,
  pidsc_in_if.sink                            req,
  pidsc_out_if.source                         rsp
);
  import pidsc_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_MUL   = 10'b00_0000_0010,
    S_ACC   = 10'b00_0000_0100,
    S_POST  = 10'b00_0000_1000,
    S_APPLY = 10'b00_0001_0000,
    S_DIV   = 10'b00_0010_0000,
    S_DFIN  = 10'b00_0100_0000,
    S_SUM   = 10'b00_1000_0000,
    S_FRZ   = 10'b01_0000_0000,
    S_FIN   = 10'b10_0000_0000
  } state_t;

  typedef enum logic [2:0] {
    OP_P   = 3'd0,
    OP_EDT = 3'd1,
    OP_D   = 3'd2,
    OP_IC  = 3'd3,
    OP_IF  = 3'd4
  } op_t;

  localparam logic signed [TERM_W:0]   TERM_MAX_X = (TERM_W+1)'(TERM_MAX);
  localparam logic signed [TERM_W+1:0] TERM_MAX_S = (TERM_W+2)'(TERM_MAX);

  function automatic logic signed [TERM_W-1:0] sat_term(input logic signed [TERM_W:0] v);
    logic signed [TERM_W-1:0] r;
    if (v > TERM_MAX_X) begin
      r = TERM_MAX;
    end else if (v < -TERM_MAX_X) begin
      r = -TERM_MAX;
    end else begin
      r = v[TERM_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    return v[32] ? 32'(-v) : 32'(v);
  endfunction

  state_t             state;
  op_t                op;
  logic signed [31:0] gain_p;
  logic signed [31:0] gain_i;
  logic signed [31:0] gain_d;
  logic [30:0]        integral_bound;
  logic [30:0]        drive_bound;
  logic signed [31:0] integral_sum;
  logic signed [32:0] last_error;
  logic signed [32:0] err;
  logic [15:0]        dt;
  logic [1:0]         ldir;
  logic signed [31:0] wlo;
  logic signed [31:0] whi;
  logic signed [31:0] ci;
  logic signed [47:0] p_term;
  logic signed [47:0] d_term;
  logic signed [47:0] i_term;
  logic signed [49:0] sum_acc;
  logic               frozen;
  logic [31:0]        mul_a;
  logic [47:0]        mul_b;
  logic [1:0]         ndig_last;
  logic               mul_neg;
  logic [47:0]        prod;
  logic [1:0]         prod_sh;
  logic [63:0]        acc;
  logic signed [48:0] shv;
  logic [4:0]         cnt;
  logic [63:0]        div_n;
  logic [15:0]        rem;
  logic               out_vld;
  logic signed [31:0] drive_q;
  status_t            status_q;
  logic               frozen_q;

  logic               out_free;
  logic               out_load;
  logic               accept;
  logic               cfg_hit;
  logic [15:0]        mul_digit;
  logic [63:0]        prod_ext;
  logic [63:0]        acc_sum;
  logic signed [64:0] acc_pos;
  logic signed [64:0] acc_sgn;
  logic signed [64:0] acc_shift;
  logic signed [32:0] err_in;
  logic signed [32:0] bound_hi;
  logic signed [32:0] bound_lo;
  logic signed [31:0] nwlo;
  logic signed [31:0] nwhi;
  logic               bad_in;
  logic               empty_win;
  logic signed [34:0] ci_raw;
  logic signed [34:0] ibound;
  logic signed [31:0] ci_next;
  logic signed [33:0] diff;
  logic [33:0]        diff_mag;
  logic [16:0]        r1;
  logic [16:0]        r1s;
  logic [16:0]        r2;
  logic [16:0]        r2s;
  logic               q1;
  logic               q0;
  logic signed [47:0] q_sat;
  logic signed [47:0] d_fin;
  logic               over_hi;
  logic               under_lo;
  logic               err_pos;
  logic               err_neg;
  logic               freeze_now;
  logic               sum_ovf;

  assign out_free  = !out_vld || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign accept    = req.valid && req.ready;
  assign out_load  = (accept && (req.action || bad_in || empty_win)) ||
                     ((state == S_FIN) && out_free);

  assign rsp.valid           = out_vld;
  assign rsp.drive           = drive_q;
  assign rsp.status          = status_q;
  assign rsp.integral_frozen = frozen_q;

  always_comb begin
    unique case (wr_index)
      REG_GAIN_P, REG_GAIN_I, REG_GAIN_D, REG_INT_BOUND, REG_DRIVE_BOUND: cfg_hit = 1'b1;
      default: cfg_hit = 1'b0;
    endcase
  end

  // Shared multiplier datapath: one 16-bit digit of mul_b per cycle.
  always_comb begin
    unique case (cnt[1:0])
      2'd0:    mul_digit = mul_b[15:0];
      2'd1:    mul_digit = mul_b[31:16];
      2'd2:    mul_digit = mul_b[47:32];
      default: mul_digit = '0;
    endcase
  end

  always_comb begin
    unique case (prod_sh)
      2'd0:    prod_ext = {16'b0, prod};
      2'd1:    prod_ext = {prod, 16'b0};
      2'd2:    prod_ext = {prod[31:0], 32'b0};
      default: prod_ext = '0;
    endcase
  end

  assign acc_sum   = acc + prod_ext;
  assign acc_pos   = $signed({1'b0, acc});
  assign acc_sgn   = mul_neg ? -acc_pos : acc_pos;
  assign acc_shift = acc_sgn >>> 16;

  // Input checks and window narrowing.
  assign err_in    = 33'(req.target_speed) - 33'(req.measured_speed);
  assign bound_hi  = $signed({2'b0, drive_bound});
  assign bound_lo  = -bound_hi;
  assign nwlo      = (33'(req.window_low) < bound_lo) ? bound_lo[31:0] : req.window_low;
  assign nwhi      = (33'(req.window_high) > bound_hi) ? bound_hi[31:0] : req.window_high;
  assign bad_in    = (req.time_step == '0) || (req.window_low > req.window_high);
  assign empty_win = nwlo > nwhi;

  // Candidate integral, clamped to the integral bound.
  assign ci_raw = 35'(integral_sum) + 35'(shv);
  assign ibound = $signed({4'b0, integral_bound});

  always_comb begin
    if (ci_raw > ibound) begin
      ci_next = 32'(ibound);
    end else if (ci_raw < -ibound) begin
      ci_next = 32'(-ibound);
    end else begin
      ci_next = ci_raw[31:0];
    end
  end

  assign diff     = 34'(err) - 34'(last_error);
  assign diff_mag = diff[33] ? 34'(-diff) : 34'(diff);

  // Radix-4 restoring division of the derivative product by the time step.
  assign r1  = {rem, div_n[63]};
  assign q1  = r1 >= {1'b0, dt};
  assign r1s = q1 ? r1 - {1'b0, dt} : r1;
  assign r2  = {r1s[15:0], div_n[62]};
  assign q0  = r2 >= {1'b0, dt};
  assign r2s = q0 ? r2 - {1'b0, dt} : r2;

  assign q_sat = (|div_n[63:47]) ? TERM_MAX : $signed({1'b0, div_n[46:0]});
  assign d_fin = mul_neg ? -q_sat : q_sat;

  assign over_hi    = sum_acc > 50'(whi);
  assign under_lo   = sum_acc < 50'(wlo);
  assign err_pos    = !err[32] && (err != '0);
  assign err_neg    = err[32];
  assign freeze_now = (over_hi && err_pos) || (under_lo && err_neg) ||
                      ((ldir == 2'b01) && err_pos) || (ldir[1] && err_neg);
  assign sum_ovf    = (sum_acc > TERM_MAX_S) || (sum_acc < -TERM_MAX_S);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_vld        <= 1'b0;
      gain_p         <= '0;
      gain_i         <= '0;
      gain_d         <= '0;
      integral_bound <= '0;
      drive_bound    <= '0;
      integral_sum   <= '0;
      last_error     <= '0;
    end else begin
      if (out_load) begin
        out_vld <= 1'b1;
      end else if (out_vld && rsp.ready) begin
        out_vld <= 1'b0;
      end

      if (wr_en) begin
        unique case (wr_index)
          REG_GAIN_P:      gain_p <= $signed(wr_data);
          REG_GAIN_I:      gain_i <= $signed(wr_data);
          REG_GAIN_D:      gain_d <= $signed(wr_data);
          REG_INT_BOUND:   integral_bound <= wr_data[30:0];
          REG_DRIVE_BOUND: drive_bound <= wr_data[30:0];
          default: ;
        endcase
        if (cfg_hit) begin
          integral_sum <= '0;
          last_error   <= '0;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.action) begin
              integral_sum <= '0;
              last_error   <= '0;
              drive_q      <= '0;
              status_q     <= ST_OK;
              frozen_q     <= 1'b0;
            end else if (bad_in) begin
              integral_sum <= '0;
              last_error   <= '0;
              drive_q      <= '0;
              status_q     <= ST_INVALID;
              frozen_q     <= 1'b0;
            end else if (empty_win) begin
              drive_q  <= '0;
              status_q <= ST_EMPTY;
              frozen_q <= 1'b0;
            end else begin
              err       <= err_in;
              dt        <= req.time_step;
              ldir      <= req.limit_direction;
              wlo       <= nwlo;
              whi       <= nwhi;
              mul_a     <= mag32(gain_p);
              mul_b     <= {16'b0, mag33(err_in)};
              mul_neg   <= gain_p[31] ^ err_in[32];
              ndig_last <= 2'd1;
              cnt       <= '0;
              acc       <= '0;
              op        <= OP_P;
              state     <= S_MUL;
            end
          end
        end

        S_MUL: begin
          prod    <= 48'(mul_a) * 48'(mul_digit);
          prod_sh <= cnt[1:0];
          if (cnt != '0) begin
            acc <= acc_sum;
          end
          cnt <= cnt + 5'd1;
          if (cnt[1:0] == ndig_last) begin
            state <= S_ACC;
          end
        end

        S_ACC: begin
          acc   <= acc_sum;
          state <= S_POST;
        end

        S_POST: begin
          if (op == OP_D) begin
            div_n <= acc;
            rem   <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end else begin
            shv   <= acc_shift[48:0];
            state <= S_APPLY;
          end
        end

        S_APPLY: begin
          unique case (op)
            OP_P: begin
              p_term    <= sat_term(shv);
              mul_a     <= mag33(err);
              mul_b     <= {32'b0, dt};
              mul_neg   <= err[32];
              ndig_last <= 2'd0;
              cnt       <= '0;
              acc       <= '0;
              op        <= OP_EDT;
              state     <= S_MUL;
            end
            OP_EDT: begin
              ci         <= ci_next;
              last_error <= err;
              mul_a      <= mag32(gain_d);
              mul_b      <= {14'b0, diff_mag};
              mul_neg    <= gain_d[31] ^ diff[33];
              ndig_last  <= 2'd2;
              cnt        <= '0;
              acc        <= '0;
              op         <= OP_D;
              state      <= S_MUL;
            end
            OP_IC, OP_IF: begin
              i_term <= sat_term(shv);
              state  <= S_SUM;
            end
            default: state <= S_IDLE;
          endcase
        end

        S_DIV: begin
          div_n <= {div_n[61:0], q1, q0};
          rem   <= r2s[15:0];
          cnt   <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            state <= S_DFIN;
          end
        end

        S_DFIN: begin
          d_term    <= d_fin;
          mul_a     <= mag32(gain_i);
          mul_b     <= {16'b0, mag32(ci)};
          mul_neg   <= gain_i[31] ^ ci[31];
          ndig_last <= 2'd1;
          cnt       <= '0;
          acc       <= '0;
          op        <= OP_IC;
          state     <= S_MUL;
        end

        S_SUM: begin
          sum_acc <= 50'(p_term) + 50'(i_term) + 50'(d_term);
          state   <= (op == OP_IC) ? S_FRZ : S_FIN;
        end

        S_FRZ: begin
          frozen <= freeze_now;
          if (freeze_now) begin
            mul_a     <= mag32(gain_i);
            mul_b     <= {16'b0, mag32(integral_sum)};
            mul_neg   <= gain_i[31] ^ integral_sum[31];
            ndig_last <= 2'd1;
            cnt       <= '0;
            acc       <= '0;
            op        <= OP_IF;
            state     <= S_MUL;
          end else begin
            integral_sum <= ci;
            state        <= S_FIN;
          end
        end

        S_FIN: begin
          if (out_free) begin
            frozen_q <= frozen;
            if (sum_ovf) begin
              integral_sum <= '0;
              last_error   <= '0;
              drive_q      <= '0;
              status_q     <= ST_OVERFLOW;
            end else begin
              status_q <= ST_OK;
              if (over_hi) begin
                drive_q <= whi;
              end else if (under_lo) begin
                drive_q <= wlo;
              end else begin
                drive_q <= $signed(sum_acc[31:0]);
              end
            end
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_clear_word: assert property (@(posedge clk) disable iff (rst)
    accept && req.action |=> (integral_sum == '0) && (last_error == '0))
    else $error("Clear word did not zero the controller state.");

  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    wr_en && cfg_hit |=> (integral_sum == '0) && (last_error == '0))
    else $error("Register write did not zero the controller state.");

  a_int_bound: assert property (@(posedge clk) disable iff (rst)
    (integral_sum[31] ? 32'(-integral_sum) : 32'(integral_sum)) <= {1'b0, integral_bound})
    else $error("Integral left its bound.");
`endif

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of pid_speed_controller_antiwindup: directed and random control
// words go through a Q16.16 PID predictor, with random gaps and stalls on both channels.
// Depends on pidsc_pkg, the channel interfaces of pidsc_if.sv and the top level.

module testbench;
  import pidsc_pkg::*;

  localparam logic              ACT_RUN       = 1'b0;
  localparam logic              ACT_CLEAR     = 1'b1;
  localparam logic [DIR_W-1:0]  DIR_NONE      = 2'b00;
  localparam logic [DIR_W-1:0]  DIR_UPPER     = 2'b01;
  localparam logic [DIR_W-1:0]  DIR_LOWER     = 2'b11;
  localparam logic [DIR_W-1:0]  DIR_LOWER_ALT = 2'b10;
  localparam logic [WORD_W-1:0] WORD_MIN      = 32'h8000_0000;
  localparam logic [WORD_W-1:0] WORD_MAX      = 32'h7FFF_FFFF;
  localparam longint            TERM_LIM      = longint'(TERM_MAX);

  typedef struct {
    logic              action;
    logic [WORD_W-1:0] target;
    logic [WORD_W-1:0] measured;
    logic [DT_W-1:0]   time_step;
    logic [DIR_W-1:0]  direction;
    logic [WORD_W-1:0] window_low;
    logic [WORD_W-1:0] window_high;
  } ctrl_word_t;

  typedef struct {
    logic [WORD_W-1:0] drive;
    status_t           status;
    logic              frozen;
  } drive_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] wr_index;
  logic [WORD_W-1:0]    wr_data;

  pidsc_in_if  req_if ();
  pidsc_out_if rsp_if ();

  pid_speed_controller_antiwindup dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .req      (req_if),
    .rsp      (rsp_if)
  );

  ctrl_word_t        pending_words[$];
  drive_result_t     expected_drives[$];
  ctrl_word_t        next_word;
  ctrl_word_t        taken_word;
  drive_result_t     want;
  logic              req_fire = 1'b0;
  logic              rsp_fire = 1'b0;
  int                src_hold = 0;
  int                snk_hold = 0;
  bit                src_quiet = 1'b0;
  bit                snk_quiet = 1'b0;
  int unsigned       mismatches = 0;
  int unsigned       results_seen = 0;
  logic [WORD_W-1:0] setpoint = '0;

  longint gain_p_q = 0;
  longint gain_i_q = 0;
  longint gain_d_q = 0;
  longint int_bound_q = 0;
  longint drv_bound_q = 0;
  longint integral_acc = 0;
  longint last_err = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint clip_term(longint v);
    if (v > TERM_LIM) return TERM_LIM;
    if (v < -TERM_LIM) return -TERM_LIM;
    return v;
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void clear_loop_state();
    integral_acc = 0;
    last_err = 0;
  endfunction

  function automatic drive_result_t control_step(ctrl_word_t w);
    drive_result_t  r;
    longint         lo, hi, err, p, ci, diff, d, i_try, i_use, cand, total, dt_s;
    longint unsigned dt_u, dmag;
    logic           dneg, hold;
    r.drive = '0;
    r.status = ST_OK;
    r.frozen = 1'b0;
    if (w.action == ACT_CLEAR) begin
      clear_loop_state();
      return r;
    end
    lo = longint'($signed(w.window_low));
    hi = longint'($signed(w.window_high));
    dt_s = longint'(w.time_step);
    dt_u = 64'(w.time_step);
    if (dt_s == 0 || lo > hi) begin
      clear_loop_state();
      r.status = ST_INVALID;
      return r;
    end
    if (lo < -drv_bound_q) lo = -drv_bound_q;
    if (hi > drv_bound_q) hi = drv_bound_q;
    if (lo > hi) begin
      r.status = ST_EMPTY;
      return r;
    end

    err = longint'($signed(w.target)) - longint'($signed(w.measured));
    p = clip_term((gain_p_q * err) >>> 16);

    ci = integral_acc + ((err * dt_s) >>> 16);
    if (ci > int_bound_q) ci = int_bound_q;
    else if (ci < -int_bound_q) ci = -int_bound_q;

    // The derivative is divided as a magnitude, so it rounds toward zero.
    diff = err - last_err;
    dmag = (magnitude(gain_d_q) * magnitude(diff)) / dt_u;
    dneg = ((gain_d_q < 0) != (diff < 0)) && gain_d_q != 0 && diff != 0;
    if (dmag > TERM_LIM) dmag = TERM_LIM;
    d = dneg ? -longint'(dmag) : longint'(dmag);
    last_err = err;

    i_try = clip_term((gain_i_q * ci) >>> 16);
    cand = p + i_try + d;
    hold = (cand > hi && err > 0) || (cand < lo && err < 0);
    if (w.direction == DIR_UPPER && err > 0) hold = 1'b1;
    if ((w.direction == DIR_LOWER || w.direction == DIR_LOWER_ALT) && err < 0) hold = 1'b1;
    if (!hold) integral_acc = ci;

    i_use = clip_term((gain_i_q * integral_acc) >>> 16);
    total = p + i_use + d;
    r.frozen = hold;
    if (total > TERM_LIM || total < -TERM_LIM) begin
      clear_loop_state();
      r.status = ST_OVERFLOW;
      return r;
    end
    if (total > hi) total = hi;
    else if (total < lo) total = lo;
    r.drive = total[WORD_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  function automatic int draw_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, 19);
  endfunction

  always begin
    repeat ($urandom_range(100, 600)) @(posedge clk);
    src_quiet = ($urandom_range(0, 3) == 0);
    snk_quiet = ($urandom_range(0, 3) == 0);
  end

  always @(negedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_fire) begin
      if (src_hold > 0) begin
        req_if.valid <= 1'b0;
        src_hold--;
      end else if (pending_words.size() != 0) begin
        next_word = pending_words.pop_front();
        req_if.action <= next_word.action;
        req_if.target_speed <= next_word.target;
        req_if.measured_speed <= next_word.measured;
        req_if.time_step <= next_word.time_step;
        req_if.limit_direction <= next_word.direction;
        req_if.window_low <= next_word.window_low;
        req_if.window_high <= next_word.window_high;
        req_if.valid <= 1'b1;
        src_hold = draw_wait(src_quiet);
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_fire) snk_hold = draw_wait(snk_quiet);
      if (rsp_if.valid && snk_hold > 0) begin
        rsp_if.ready <= 1'b0;
        snk_hold--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Results are checked before the word accepted at the same edge is predicted.
  always @(posedge clk) begin
    req_fire <= req_if.valid && req_if.ready;
    rsp_fire <= rsp_if.valid && rsp_if.ready;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      results_seen++;
      if (expected_drives.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = expected_drives.pop_front();
        if (rsp_if.drive !== want.drive)
          report_mismatch($sformatf("result %0d drive %h, expected %h",
                                    results_seen, rsp_if.drive, want.drive));
        if (rsp_if.status !== want.status)
          report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                    results_seen, rsp_if.status, want.status));
        if (rsp_if.integral_frozen !== want.frozen)
          report_mismatch($sformatf("result %0d integral_frozen %b, expected %b",
                                    results_seen, rsp_if.integral_frozen, want.frozen));
      end
    end
    if (!rst && req_if.valid && req_if.ready) begin
      taken_word.action = req_if.action;
      taken_word.target = req_if.target_speed;
      taken_word.measured = req_if.measured_speed;
      taken_word.time_step = req_if.time_step;
      taken_word.direction = req_if.limit_direction;
      taken_word.window_low = req_if.window_low;
      taken_word.window_high = req_if.window_high;
      expected_drives.push_back(control_step(taken_word));
    end
  end

  function automatic logic [WORD_W-1:0] q16(int v);
    return v <<< 16;
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return $urandom_range(0, 2) == 0 ? '0 : ($urandom_range(0, 1) ? '1 : 32'd1);
      3, 4, 5: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
      2, 3, 4: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      5, 6: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_bound();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return $urandom();
      2: return WORD_MAX;
      default: return $urandom_range(1, 32'h0400_0000);
    endcase
  endfunction

  task automatic queue_word(logic act, logic [WORD_W-1:0] tgt, logic [WORD_W-1:0] meas,
                            logic [DT_W-1:0] dt, logic [DIR_W-1:0] dir,
                            logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi);
    ctrl_word_t w;
    w.action = act;
    w.target = tgt;
    w.measured = meas;
    w.time_step = dt;
    w.direction = dir;
    w.window_low = lo;
    w.window_high = hi;
    pending_words.push_back(w);
  endtask

  task automatic queue_random_word();
    logic [WORD_W-1:0] tgt, meas, lo, hi, tmp;
    logic [DT_W-1:0]   dt;
    logic [DIR_W-1:0]  dir;
    logic              act;
    if ($urandom_range(0, 19) == 0) setpoint = pick_word();
    act = ($urandom_range(0, 24) == 0) ? ACT_CLEAR : ACT_RUN;
    // Most words track a held setpoint so that the integral builds up.
    if ($urandom_range(0, 9) < 7) begin
      tgt = setpoint;
      meas = setpoint + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    end else begin
      tgt = pick_word();
      meas = pick_word();
    end
    case ($urandom_range(0, 29))
      0: dt = '0;
      1: dt = '1;
      2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14: dt = DT_W'($urandom_range(1, 4095));
      default: dt = DT_W'($urandom());
    endcase
    dir = ($urandom_range(0, 9) < 6) ? DIR_NONE : DIR_W'($urandom());
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        hi = ($urandom_range(0, 3) == 0) ? {1'b0, 31'($urandom())}
                                         : $urandom_range(0, 32'h1000_0000);
        lo = -hi;
      end
      9: begin
        lo = pick_word();
        hi = pick_word();
      end
      default: begin
        lo = pick_word();
        hi = pick_word();
        if ($signed(lo) > $signed(hi)) begin
          tmp = lo;
          lo = hi;
          hi = tmp;
        end
      end
    endcase
    queue_word(act, tgt, meas, dt, dir, lo, hi);
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || req_if.valid || expected_drives.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(negedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_GAIN_P:      gain_p_q = longint'($signed(val));
      REG_GAIN_I:      gain_i_q = longint'($signed(val));
      REG_GAIN_D:      gain_d_q = longint'($signed(val));
      REG_INT_BOUND:   int_bound_q = longint'(val[BOUND_W-1:0]);
      REG_DRIVE_BOUND: drv_bound_q = longint'(val[BOUND_W-1:0]);
      default: return;
    endcase
    clear_loop_state();
  endtask

  task automatic load_gains(logic [WORD_W-1:0] kp, logic [WORD_W-1:0] ki,
                            logic [WORD_W-1:0] kd, logic [WORD_W-1:0] ibound,
                            logic [WORD_W-1:0] dbound);
    write_reg(REG_GAIN_P, kp);
    write_reg(REG_GAIN_I, ki);
    write_reg(REG_GAIN_D, kd);
    write_reg(REG_INT_BOUND, ibound);
    write_reg(REG_DRIVE_BOUND, dbound);
  endtask

  initial begin
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    req_if.valid = 1'b0;
    req_if.action = ACT_RUN;
    req_if.target_speed = '0;
    req_if.measured_speed = '0;
    req_if.time_step = '0;
    req_if.limit_direction = DIR_NONE;
    req_if.window_low = '0;
    req_if.window_high = '0;
    rsp_if.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // With the reset bounds the window narrows to a single zero point or to nothing.
    queue_word(ACT_RUN, q16(3), q16(1), 16'h1000, DIR_NONE, q16(-100), q16(100));
    queue_word(ACT_RUN, q16(3), q16(1), 16'h1000, DIR_NONE, q16(1), q16(5));
    drain();

    load_gains(q16(1), 32'h0000_8000, 32'h0000_4000, q16(10), q16(50));
    queue_word(ACT_CLEAR, $urandom(), $urandom(), DT_W'($urandom()), DIR_W'($urandom()),
               $urandom(), $urandom());
    queue_word(ACT_RUN, q16(5), q16(2), 16'h0800, DIR_NONE, q16(-100), q16(100));
    queue_word(ACT_RUN, q16(5), q16(2), 16'h0800, DIR_NONE, q16(-100), q16(100));
    queue_word(ACT_RUN, q16(5), q16(2), 16'h0000, DIR_NONE, q16(-100), q16(100));
    queue_word(ACT_RUN, q16(5), q16(2), 16'h0800, DIR_NONE, q16(4), q16(3));
    queue_word(ACT_RUN, q16(2), q16(5), 16'h0800, DIR_NONE, q16(-100), q16(100));
    queue_word(ACT_RUN, q16(5), q16(2), 16'h0800, DIR_UPPER, q16(-100), q16(100));
    queue_word(ACT_RUN, q16(2), q16(5), 16'h0800, DIR_LOWER, q16(-100), q16(100));
    queue_word(ACT_RUN, q16(2), q16(5), 16'h0800, DIR_LOWER_ALT, q16(-100), q16(100));
    queue_word(ACT_RUN, q16(5), q16(2), 16'h0800, DIR_LOWER, q16(-100), q16(100));
    queue_word(ACT_RUN, WORD_MAX, WORD_MIN, 16'hFFFF, DIR_NONE, WORD_MIN, WORD_MAX);
    queue_word(ACT_RUN, WORD_MIN, WORD_MAX, 16'h0001, DIR_NONE, WORD_MIN, WORD_MAX);
    queue_word(ACT_RUN, q16(5), q16(2), 16'h0800, DIR_NONE, q16(60), q16(70));
    queue_word(ACT_RUN, q16(5), q16(2), 16'h0800, DIR_NONE, q16(3), q16(3));
    queue_word(ACT_CLEAR, '0, '0, '0, DIR_NONE, '0, '0);
    drain();

    load_gains(WORD_MAX, WORD_MIN, WORD_MAX, 32'hFFFF_FFFF, WORD_MAX);
    queue_word(ACT_RUN, WORD_MAX, WORD_MIN, 16'h0001, DIR_NONE, WORD_MIN, WORD_MAX);
    queue_word(ACT_RUN, WORD_MAX, WORD_MIN, 16'h0001, DIR_UPPER, WORD_MIN, WORD_MAX);
    queue_word(ACT_RUN, '0, '0, 16'hFFFF, DIR_NONE, WORD_MIN, WORD_MAX);
    queue_word(ACT_RUN, 32'd1, '0, 16'hFFFF, DIR_LOWER_ALT, q16(-1), q16(1));
    queue_word(ACT_RUN, WORD_MIN, WORD_MAX, 16'h8000, DIR_LOWER, WORD_MIN, WORD_MAX);
    drain();

    load_gains('0, '0, WORD_MIN, WORD_MAX, WORD_MIN);
    queue_word(ACT_RUN, WORD_MAX, WORD_MIN, 16'hFFFF, DIR_NONE, WORD_MIN, WORD_MAX);
    queue_word(ACT_RUN, 32'h5555_5555, 32'hAAAA_AAAA, 16'hAAAA, DIR_UPPER, WORD_MIN, '0);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      load_gains(pick_gain(), pick_gain(), pick_gain(), pick_bound(), pick_bound());
      repeat (88) queue_random_word();
      drain();
      // An unlisted register index must leave the gains and the loop state alone.
      write_reg(REG_IDX_W'($urandom_range(int'(REG_DRIVE_BOUND) + 1, (1 << REG_IDX_W) - 1)),
                $urandom());
      repeat (87) queue_random_word();
    end

    drain();
    repeat (70) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

### files.f
src/pidsc_pkg.sv
src/pidsc_if.sv
src/pid_speed_controller_antiwindup.sv
sim/testbench.sv
